>>> hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FIELD_W       = FRACTION_BITS + 1;
  localparam int CHAN_W        = 8;
  localparam int CHAN_MAX      = 255;

  // Chroma fits in two fields' product, less the fraction bits.
  localparam int CHROMA_W = 2 * FIELD_W - FRACTION_BITS;
  // Six times the hue needs three more bits.
  localparam int HUE6_W   = FIELD_W + 3;
  localparam int SECTOR_W = HUE6_W - FRACTION_BITS;
  // Signed channel sum: chroma plus sign plus one bit of headroom.
  localparam int SUM_W    = CHROMA_W + 2;

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1) << FRACTION_BITS;

  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [CHROMA_W-1:0] chroma_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

>>> hdl/hsv2rgb_if.sv
interface hsv2rgb_pix_if;
  import hsv2rgb_pkg::*;

  logic   valid;
  logic   ready;
  field_t hue;
  field_t saturation;
  field_t brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  import hsv2rgb_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> hdl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// The pix channel carries one pixel as hue, saturation and brightness, all
// unsigned Q16 fractions; a hue of one full turn or more gives a grey pixel.
// The rgb channel returns one request per pixel with 8-bit red, green and
// blue, truncated and clamped to 0..255.
// The datapath is a four-stage pipeline: chroma and sector, then x and the
// grey offset, then the channel sums, then scaling and clamping into the
// output register. One pixel is accepted in every cycle while the receiver
// takes results. Each stage holds its own valid bit and moves on whenever
// the stage after it is empty or moving, so bubbles close up during a
// stall. When rgb.ready is low and the pipeline is full, pix.ready drops
// and every stage holds. Synchronous reset clears all valid bits; no
// request is lost or repeated.
module hsv_to_rgb_converter (
  input  logic                clk,
  input  logic                rst,
  hsv2rgb_pix_if.sink         pix,
  hsv2rgb_rgb_if.source       rgb
);
  import hsv2rgb_pkg::*;

  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_GRN = SECTOR_W'(0),
    SEC_GRN_RED = SECTOR_W'(1),
    SEC_GRN_BLU = SECTOR_W'(2),
    SEC_BLU_GRN = SECTOR_W'(3),
    SEC_BLU_RED = SECTOR_W'(4),
    SEC_RED_BLU = SECTOR_W'(5)
  } sector_t;

  function automatic chan_t to_chan(input sum_t val);
    logic [SUM_W-2:0]      pos;
    logic [SUM_W+CHAN_W-2:0] prod;
    logic [SUM_W+CHAN_W-2-FRACTION_BITS:0] scaled;
    pos    = val[SUM_W-2:0];
    prod   = {pos, CHAN_W'(0)} - {CHAN_W'(0), pos};
    scaled = prod[SUM_W+CHAN_W-2:FRACTION_BITS];
    if (val <= 0) begin
      return '0;
    end else if (scaled > CHAN_MAX) begin
      return chan_t'(CHAN_MAX);
    end
    return scaled[CHAN_W-1:0];
  endfunction

  // Stage valid bits and advance conditions.
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4 || rgb.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix.ready = adv1;

  // Stage 1: chroma, sector and the tent term one - |t - one|.
  logic [2*FIELD_W-1:0] vs_prod;
  logic [HUE6_W-1:0]    hue6;
  field_t               hue_frac;
  field_t               hue_dist;
  field_t               tent_next;

  assign vs_prod  = pix.brightness * pix.saturation;
  assign hue6     = HUE6_W'(pix.hue) * HUE6_W'(6);
  assign hue_frac = hue6[FIELD_W-1:0];
  assign hue_dist = (hue_frac >= ONE) ? (hue_frac - ONE) : (ONE - hue_frac);
  assign tent_next = ONE - hue_dist;

  chroma_t chroma1;
  field_t  tent1;
  field_t  bright1;
  sector_t sector1;

  // Stage 2: x and the grey offset m = v - c.
  logic [CHROMA_W+FIELD_W-1:0] x_prod;
  sum_t                        offset_next;

  assign x_prod      = chroma1 * tent1;
  assign offset_next = sum_t'({2'b00, bright1}) - sum_t'({1'b0, chroma1});

  chroma_t chroma2;
  chroma_t xval2;
  sum_t    offset2;
  sector_t sector2;

  // Stage 3: route chroma and x to channels, add the offset.
  chroma_t sel_r, sel_g, sel_b;

  always_comb begin
    sel_r = '0;
    sel_g = '0;
    sel_b = '0;
    case (sector2)
      SEC_RED_GRN: begin sel_r = chroma2; sel_g = xval2;   end
      SEC_GRN_RED: begin sel_r = xval2;   sel_g = chroma2; end
      SEC_GRN_BLU: begin sel_g = chroma2; sel_b = xval2;   end
      SEC_BLU_GRN: begin sel_g = xval2;   sel_b = chroma2; end
      SEC_BLU_RED: begin sel_r = xval2;   sel_b = chroma2; end
      SEC_RED_BLU: begin sel_r = chroma2; sel_b = xval2;   end
      default: begin end
    endcase
  end

  sum_t sum_r3, sum_g3, sum_b3;

  // Stage 4 output register.
  chan_t red4, green4, blue4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pix.valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      chroma1 <= vs_prod[FRACTION_BITS +: CHROMA_W];
      tent1   <= tent_next;
      bright1 <= pix.brightness;
      sector1 <= sector_t'(hue6[HUE6_W-1:FRACTION_BITS]);
    end
    if (adv2) begin
      chroma2 <= chroma1;
      xval2   <= x_prod[FRACTION_BITS +: CHROMA_W];
      offset2 <= offset_next;
      sector2 <= sector1;
    end
    if (adv3) begin
      sum_r3 <= sum_t'({2'b00, sel_r}) + offset2;
      sum_g3 <= sum_t'({2'b00, sel_g}) + offset2;
      sum_b3 <= sum_t'({2'b00, sel_b}) + offset2;
    end
    if (adv4) begin
      red4   <= to_chan(sum_r3);
      green4 <= to_chan(sum_g3);
      blue4  <= to_chan(sum_b3);
    end
  end

  assign rgb.valid = v4;
  assign rgb.red   = red4;
  assign rgb.green = green4;
  assign rgb.blue  = blue4;

endmodule

>>> hdl/hsv2rgb_check.sv
module hsv2rgb_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input hsv2rgb_pkg::chan_t   red,
  input hsv2rgb_pkg::chan_t   green,
  input hsv2rgb_pkg::chan_t   blue
);
  import hsv2rgb_pkg::*;

  // A stalled result keeps its request and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
    else $error("rgb request changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("rgb request present right after reset");

  // A ready receiver never back-pressures the pixel side.
  a_ready_flow: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("pix stalled while rgb side is ready");

  // With the receiver ready throughout, an accepted pixel passes the stage registers without a hold.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && in_ready, 4) && !$past(rst, 1) && !$past(rst, 2)
      && !$past(rst, 3) && !$past(rst, 4) && $past(out_ready, 1)
      && $past(out_ready, 2) && $past(out_ready, 3)
    |-> out_valid)
    else $error("rgb result missing four cycles after its pixel");

endmodule

bind hsv_to_rgb_converter hsv2rgb_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);
